FILE: sv/nlms_pkg.sv
// ----------------------------------------------------------------------------
// nlms_pkg
// Shared sizes, register indexes and helpers for the nlms adaptive fir
// ----------------------------------------------------------------------------
package nlms_pkg;

  localparam int TAPS      = 16;
  localparam int IDX_W     = $clog2(TAPS);
  localparam int FILL_W    = $clog2(TAPS + 1);

  localparam int S_W       = 16;              // sample width
  localparam int W_W       = 32;              // weight width, Q4.28
  localparam int STEP_W    = 15;
  localparam int LIM_W     = 16;
  localparam int TAP_OUT_W = 6;

  localparam int EST_W     = W_W + S_W + IDX_W;   // dot product accumulator
  localparam int EN_W      = 2 * S_W - 1 + IDX_W; // energy accumulator
  localparam int ES_W      = W_W + STEP_W;        // err * step
  localparam int NUM_W     = ES_W + S_W;          // magnitude of 2*err*step*x
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP_LIMIT = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET  = 15'd16384;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 16'hFFFF;

  // saturate a signed 64-bit value to signed 32 bits
  function automatic logic signed [W_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[W_W-1:0];
    end
  endfunction

endpackage

FILE: sv/nlms_div.sv
// ----------------------------------------------------------------------------
// nlms_div
// Restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nlms_div import nlms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  dividend_i,
  input  logic [EN_W-1:0]   divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [NUM_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [EN_W-1:0]  rem_q;
  logic [NUM_W-1:0] dq_q;
  logic             done_q;
  logic [EN_W:0]    shifted;
  logic             ge;

  // trial subtract of the shifted remainder
  assign shifted = {rem_q, dq_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? EN_W'(shifted - {1'b0, divisor_i}) : shifted[EN_W-1:0];
      dq_q  <= {dq_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: sv/nlms_adaptive_fir.sv
// ----------------------------------------------------------------------------
// nlms_adaptive_fir
// Normalized LMS adaptive FIR identifier with periodic weight snapshots
// ----------------------------------------------------------------------------
// Input stream: each transfer carries one sample and its desired response.
// Until TAPS samples have arrived a sample is only stored.
// After that every item runs the adaptation on one shared multiplier and
// one shared bit-serial divider under a small sequencer:
//   accept
//   dot product and energy, per tap
//   error and err*step
//   weight update, per tap (63-step divide)
//   snapshot decision
// followed by TAPS output words on a snapshot item; a zero-energy window
// skips the update. s_axis_tready_o is low meanwhile.
// On the first adapting item and every TAPS-th one after it a snapshot of
// TAPS weights leaves on the output stream, newest-sample tap first, tlast
// on the final one, until snapshot_limit snapshots have gone out.
// The output register holds a result while the receiver stalls; the
// sequencer waits for it. Reset clears samples, weights and counters and
// restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nlms_adaptive_fir import nlms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample_in [15:0], desired_in [31:16]
  input  logic [31:0]           s_axis_tdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tap_index [5:0], weight_out [37:6], zero fill [39:38]
  output logic [39:0]           m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_EST_MUL, S_EST_ACC, S_EN_ACC, S_ERR, S_ES_MUL, S_ES_LD,
    S_UPD_MUL, S_DIV_GO, S_DIV_WAIT, S_SNAP, S_OUT
  } state_e;

  state_e                   state_q;
  logic [STEP_W-1:0]        step_q;
  logic [LIM_W-1:0]         limit_q;
  logic signed [S_W-1:0]    win_q [TAPS];
  logic signed [W_W-1:0]    wgt_q [TAPS];
  logic [FILL_W-1:0]        fill_q;
  logic [IDX_W-1:0]         phase_q;
  logic [LIM_W-1:0]         snaps_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [S_W-1:0]    des_q;
  logic signed [EST_W-1:0]  est_q;
  logic [EN_W-1:0]          en_q;
  logic signed [W_W-1:0]    err_q;
  logic signed [ES_W-1:0]   es_q;
  logic                     neg_q;
  logic signed [MUL_P_W-1:0] mul_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                     out_valid_q;
  logic [TAP_OUT_W-1:0]     out_tap_q;
  logic signed [W_W-1:0]    out_w_q;
  logic                     out_last_q;

  logic                     in_xfer;
  logic [FILL_W-1:0]        fill_next;
  logic signed [EST_W:0]    diff;
  logic signed [EST_W-15:0] diff_sh;
  logic signed [63:0]       num;
  logic [NUM_W-1:0]         num_mag;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [NUM_W-1:0]         quot;
  logic signed [63:0]       quot_s;
  logic signed [63:0]       wsum;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign fill_next = (fill_q == FILL_W'(TAPS)) ? fill_q : fill_q + 1'b1;

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_EST_MUL: begin
        mul_a = MUL_A_W'(wgt_q[idx_q]);
        mul_b = win_q[idx_q];
      end
      S_ES_MUL: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = $signed({1'b0, step_q});
      end
      S_UPD_MUL: begin
        mul_a = MUL_A_W'(es_q);
        mul_b = win_q[idx_q];
      end
      default: begin
        mul_a = MUL_A_W'(win_q[idx_q]);
        mul_b = win_q[idx_q];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // error: desired*2^28 - estimate, floored by 2^15
  assign diff    = ($signed((EST_W + 1)'(des_q)) <<< 28) - (EST_W + 1)'(est_q);
  assign diff_sh = diff[EST_W:15];

  // signed numerator and its magnitude for the divider
  assign num       = mul_q <<< 1;
  assign num_mag   = num[63] ? NUM_W'(-num) : NUM_W'(num);
  assign div_start = state_q == S_DIV_GO;

  nlms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (en_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign quot_s = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign wsum   = 64'(wgt_q[idx_q]) + quot_s;

  // sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_RESET;
      limit_q     <= LIMIT_RESET;
      fill_q      <= '0;
      phase_q     <= '0;
      snaps_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= '0;
        wgt_q[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_SIZE:  step_q  <= cfg_data_i[STEP_W-1:0];
          REG_SNAP_LIMIT: limit_q <= cfg_data_i[LIM_W-1:0];
          default: ;
        endcase
      end

      // output register empties on a transfer; S_OUT handles its own refill
      if (out_valid_q && m_axis_tready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            for (int i = 0; i < TAPS - 1; i++) begin
              win_q[i] <= win_q[i+1];
            end
            win_q[TAPS-1] <= s_axis_tdata_i[15:0];
            des_q  <= s_axis_tdata_i[31:16];
            fill_q <= fill_next;
            if (fill_next == FILL_W'(TAPS)) begin
              idx_q   <= '0;
              est_q   <= '0;
              en_q    <= '0;
              state_q <= S_EST_MUL;
            end
          end
        end
        S_EST_MUL: state_q <= S_EST_ACC;
        S_EST_ACC: begin
          est_q   <= est_q + EST_W'(mul_q);
          state_q <= S_EN_ACC;
        end
        S_EN_ACC: begin
          en_q <= en_q + EN_W'(mul_q);
          if (idx_q == IDX_W'(TAPS - 1)) begin
            state_q <= S_ERR;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_EST_MUL;
          end
        end
        S_ERR: begin
          err_q <= sat32(64'(diff_sh));
          idx_q <= '0;
          state_q <= (en_q == '0) ? S_SNAP : S_ES_MUL;
        end
        S_ES_MUL: state_q <= S_ES_LD;
        S_ES_LD: begin
          es_q    <= mul_q[ES_W-1:0];
          state_q <= S_UPD_MUL;
        end
        S_UPD_MUL: state_q <= S_DIV_GO;
        S_DIV_GO: begin
          neg_q   <= num[63];
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            wgt_q[idx_q] <= sat32(wsum);
            if (idx_q == IDX_W'(TAPS - 1)) begin
              state_q <= S_SNAP;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_UPD_MUL;
            end
          end
        end
        S_SNAP: begin
          phase_q <= (phase_q == IDX_W'(TAPS - 1)) ? '0 : phase_q + 1'b1;
          if (phase_q == '0 && snaps_q < limit_q) begin
            snaps_q <= snaps_q + 1'b1;
            idx_q   <= IDX_W'(TAPS - 1);
            state_q <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_tap_q   <= TAP_OUT_W'(TAPS - 1) - TAP_OUT_W'(idx_q);
            out_w_q     <= wgt_q[idx_q];
            out_last_q  <= idx_q == '0;
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b00, out_w_q, out_tap_q};

  // the input side never opens while a divide runs
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("input ready during divide");

  // a divide start is followed by a running divider
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");

  // tlast marks the oldest-sample tap only
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (out_tap_q == TAP_OUT_W'(TAPS - 1)))
    else $error("tlast on wrong tap");

endmodule

FILE: tb/tb_nlms_adaptive_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nlms_adaptive_fir
// Self-checking stream testbench for the nlms adaptive fir identifier
// ----------------------------------------------------------------------------
// A queue of sample/desired pairs feeds a clocked driver; a clocked monitor
// compares every weight snapshot transfer against a bit-exact predictor of
// the adaptation. Step size and snapshot limit change between phases while
// the block is idle. Both sides idle at random, and the receiver holds off
// once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_nlms_adaptive_fir import nlms_pkg::*;;

  localparam int HOLD_CYCLES = 4000;
  localparam int WATCHDOG    = 20000;
  localparam int SETTLE      = 1500;

  typedef struct packed {
    logic [TAP_OUT_W-1:0]  tap;
    logic signed [W_W-1:0] weight;
    logic                  last;
  } snap_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // pending input pairs and expected snapshot words
  logic [31:0] pair_q[$];
  snap_word_t  snap_q[$];

  // predictor state
  logic [STEP_W-1:0]     gain;
  logic [LIM_W-1:0]      snap_limit;
  logic signed [S_W-1:0] window[TAPS];
  logic signed [W_W-1:0] coef[TAPS];
  int unsigned           fill_cnt, phase_cnt, snaps_sent;

  int unsigned n_in = 0;
  int unsigned fails = 0;
  int unsigned quiet = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 0;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nlms_adaptive_fir DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  function automatic logic signed [W_W-1:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[W_W-1:0];
  endfunction

  // shift in one sample, adapt and queue any snapshot
  task automatic adapt_pair(input logic [31:0] pair);
    logic signed [63:0] est, energy, err, num;
    snap_word_t w;
    est = 0;
    energy = 0;
    for (int i = 0; i < TAPS - 1; i++) window[i] = window[i+1];
    window[TAPS-1] = pair[15:0];
    if (fill_cnt < TAPS) fill_cnt++;
    if (fill_cnt < TAPS) return;
    for (int i = 0; i < TAPS; i++) begin
      est += 64'(coef[i]) * 64'(window[i]);
      energy += 64'(window[i]) * 64'(window[i]);
    end
    err = (64'(signed'(pair[31:16])) <<< 28) - est;
    err = 64'(clamp32(err >>> 15));
    if (energy != 0) begin
      for (int i = 0; i < TAPS; i++) begin
        num = err * 64'(signed'({1'b0, gain}));
        num = num * 64'(window[i]) * 2;
        coef[i] = clamp32(64'(coef[i]) + num / energy);
      end
    end
    if (phase_cnt == 0 && snaps_sent < snap_limit) begin
      for (int i = 0; i < TAPS; i++) begin
        w.tap = TAP_OUT_W'(i);
        w.weight = coef[TAPS-1-i];
        w.last = (i == TAPS - 1);
        snap_q.push_back(w);
      end
      snaps_sent++;
    end
    phase_cnt = (phase_cnt + 1) % TAPS;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error: %s got %0h expected %0h (snapshot word)", what, got, want);
    fails++;
  endtask

  function automatic bit no_idle();
    return n_in >= 300 && n_in < 360;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        adapt_pair(s_tdata);
        n_in <= n_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pair_q.size() > 0 && (no_idle() || $urandom_range(0, 99) >= 19)) begin
          s_tdata <= pair_q.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once the run is well under way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (!hold_done && n_in >= 200) begin
        hold_done <= 1;
        hold_cnt <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle() || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    snap_word_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (snap_q.size() == 0) begin
        report("unexpected transfer", 64'(m_tdata), 64'(0));
      end else begin
        want = snap_q.pop_front();
        if (m_tdata[5:0] !== want.tap)
          report("tap_index", 64'(m_tdata[5:0]), 64'(want.tap));
        if (m_tdata[37:6] !== want.weight)
          report("weight_out", 64'(m_tdata[37:6]), 64'(unsigned'(want.weight)));
        if (m_tlast !== want.last)
          report("last", 64'(m_tlast), 64'(want.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("nlms_adaptive_fir: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_STEP_SIZE) gain = val[STEP_W-1:0];
    else snap_limit = val;
  endtask

  // wait until every pair is taken and every snapshot word has come back
  task automatic drain();
    while (pair_q.size() != 0 || s_tvalid || snap_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random(input int cnt);
    for (int i = 0; i < cnt; i++) begin
      // an occasional run of zeros brings the window energy back to zero
      if ($urandom_range(0, 99) == 0) begin
        for (int k = 0; k < TAPS; k++) pair_q.push_back({16'($urandom), 16'h0000});
      end
      pair_q.push_back({rand_sample(), rand_sample()});
    end
  endtask

  initial begin
    gain = STEP_RESET;
    snap_limit = LIMIT_RESET;
    fill_cnt = 0;
    phase_cnt = 0;
    snaps_sent = 0;
    for (int i = 0; i < TAPS; i++) begin
      window[i] = '0;
      coef[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill with zeros (desired ignored), a zero-energy step, extremes
    for (int i = 0; i < TAPS; i++) pair_q.push_back({16'h7FFF - 16'(i), 16'h0000});
    pair_q.push_back({16'h8000, 16'h0000});
    pair_q.push_back({16'h7FFF, 16'h7FFF});
    pair_q.push_back({16'h8000, 16'h8000});
    pair_q.push_back({16'h7FFF, 16'h8000});
    pair_q.push_back({16'h8000, 16'h7FFF});
    pair_q.push_back({16'h0000, 16'h0001});
    pair_q.push_back({16'hFFFF, 16'hFFFF});
    drain();

    // largest gain, few snapshots
    write_reg(REG_STEP_SIZE, 16'h7FFF);
    write_reg(REG_SNAP_LIMIT, 16'd4);
    add_random(90);
    drain();

    // no adaptation, no snapshots beyond those already sent
    write_reg(REG_STEP_SIZE, 16'h0000);
    write_reg(REG_SNAP_LIMIT, 16'h0000);
    add_random(30);
    drain();

    // random gain, full limit, carries the long hold-off
    write_reg(REG_STEP_SIZE, 16'($urandom_range(1, 32766)));
    write_reg(REG_SNAP_LIMIT, 16'hFFFF);
    add_random(170);
    drain();

    write_reg(REG_STEP_SIZE, 16'd16384);
    add_random(100);
    drain();

    if (fails == 0) begin
      $display("nlms_adaptive_fir: match");
    end else begin
      $display("nlms_adaptive_fir: mismatch");
    end
    $finish;
  end

endmodule
